// File: rtl/core/pkc_pkg.sv
// shared types and constants for the power key press classifier
package pkc_pkg;

  localparam int CountW = 16;
  localparam int CfgIdxW = 2;

  localparam logic [CountW-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [CountW-1:0] COUNT_ONE = 16'h0001;

  localparam logic [1:0] PH_READY = 2'd0;
  localparam logic [1:0] PH_PRESS = 2'd1;
  localparam logic [1:0] PH_WAIT  = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_OFF_COUNT   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_FORCE_COUNT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_FORCED_TMO  = 2'd2;

  typedef struct packed {
    logic [CountW-1:0] off_count;
    logic [CountW-1:0] force_count;
    logic [CountW-1:0] forced_on_timeout;
  } cfg_regs_t;

  typedef struct packed {
    logic force_set;
  } scan_event_t;

endpackage

// File: rtl/core/pkc_cfg.sv
// configuration register file
module pkc_cfg import pkc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CountW-1:0]  cfg_data,
  output cfg_regs_t          regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.off_count         <= 16'd200;
      regs.force_count       <= 16'd500;
      regs.forced_on_timeout <= 16'd60000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFF_COUNT:   regs.off_count         <= cfg_data;
        REG_FORCE_COUNT: regs.force_count       <= cfg_data;
        REG_FORCED_TMO:  regs.forced_on_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/pkc_scan.sv
// key scanner: phase machine, press counter and latched flags
module pkc_scan import pkc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              key_pressed,
  input  logic              clear_turn_off,
  input  cfg_regs_t         regs,
  output scan_event_t       evt,
  output logic              turn_off_code,
  output logic              press_trigger,
  output logic [1:0]        phase,
  output logic [CountW-1:0] press_ticks
);

  logic              released_once;
  logic [1:0]        phase_next;
  logic [CountW-1:0] press_ticks_next;
  logic [CountW-1:0] ticks_inc;
  logic              released_once_next;
  logic              turn_off_next;
  logic              trigger_next;
  logic              force_set;

  assign ticks_inc = (press_ticks == COUNT_MAX) ? press_ticks : press_ticks + COUNT_ONE;

  always_comb begin
    phase_next         = phase;
    press_ticks_next   = press_ticks;
    released_once_next = released_once;
    turn_off_next      = turn_off_code & ~clear_turn_off;
    trigger_next       = press_trigger;
    force_set          = 1'b0;
    unique case (phase)
      PH_READY: begin
        if (key_pressed) begin
          press_ticks_next = COUNT_ONE;
          trigger_next     = 1'b1;
          phase_next       = PH_PRESS;
        end else begin
          press_ticks_next   = '0;
          released_once_next = 1'b1;
        end
      end
      PH_PRESS: begin
        if (key_pressed) begin
          press_ticks_next = ticks_inc;
          // force-on only for a key held since power-up
          if (!released_once && ticks_inc >= regs.force_count) begin
            force_set  = 1'b1;
            phase_next = PH_WAIT;
          end
        end else begin
          if (press_ticks >= regs.off_count) turn_off_next = 1'b1;
          phase_next = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (!key_pressed) phase_next = PH_READY;
      end
      default: phase_next = PH_READY;
    endcase
  end

  assign evt.force_set = force_set;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_READY;
      press_ticks   <= '0;
      released_once <= 1'b0;
      turn_off_code <= 1'b0;
      press_trigger <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      press_ticks   <= press_ticks_next;
      released_once <= released_once_next;
      turn_off_code <= turn_off_next;
      press_trigger <= trigger_next;
    end
  end

endmodule

// File: rtl/core/pkc_timeout.sv
// force-on code and forced-on timeout stage
module pkc_timeout import pkc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  scan_event_t evt,
  input  cfg_regs_t   regs,
  output logic        force_on_code,
  output logic        forced_on
);

  logic [CountW-1:0] forced_ticks;
  logic [CountW-1:0] forced_ticks_next;
  logic [CountW-1:0] ticks_inc;
  logic              code_now;
  logic              force_on_code_next;
  logic              forced_on_next;

  // code as left by the scanner in this tick
  assign code_now  = force_on_code | evt.force_set;
  assign ticks_inc = forced_ticks + COUNT_ONE;

  always_comb begin
    forced_ticks_next  = forced_ticks;
    forced_on_next     = forced_on;
    force_on_code_next = code_now;
    if (forced_on) begin
      if (ticks_inc >= regs.forced_on_timeout) begin
        forced_ticks_next = '0;
        forced_on_next    = 1'b0;
      end else begin
        forced_ticks_next = ticks_inc;
      end
    end else if (code_now) begin
      forced_ticks_next  = '0;
      forced_on_next     = 1'b1;
      force_on_code_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      force_on_code <= 1'b0;
      forced_on     <= 1'b0;
      forced_ticks  <= '0;
    end else if (accept) begin
      force_on_code <= force_on_code_next;
      forced_on     <= forced_on_next;
      forced_ticks  <= forced_ticks_next;
    end
  end

endmodule

// File: rtl/core/power_key_press_classifier.sv
// top level of the power key press classifier
//
// one input transaction is one scan tick: key_pressed is the sampled key
// level and clear_turn_off drops a latched turn-off request before the tick
// is evaluated. every input transaction yields exactly one result
// transaction that shows the state after that tick.
// latency: the result is valid in the cycle after the input is taken.
// throughput: one tick per cycle; the state registers double as the result
// register, so a new tick is taken whenever the result is taken in the same
// cycle or no result is waiting.
// when the receiver stalls, the result holds and item_stall is raised until
// the result leaves; no tick is lost or repeated.
// configuration: cfg_we writes cfg_data into register cfg_index (0 off
// count, 1 force count, 2 forced-on timeout); other indexes are ignored.
// reset clears all scan state and restores thresholds 200, 500 and 60000;
// no result is pending after reset.
module power_key_press_classifier import pkc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               key_pressed,
  input  logic               clear_turn_off,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               turn_off_request,
  output logic               force_on_pending,
  output logic               forced_on_active,
  output logic               press_seen,
  output logic [1:0]         scan_phase,
  output logic [CountW-1:0]  held_ticks,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CountW-1:0]  cfg_data
);

  cfg_regs_t   regs;
  scan_event_t evt;
  logic        accept;

  assign item_stall = result_valid & result_stall;
  assign accept     = item_valid & ~item_stall;

  pkc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  pkc_scan u_scan (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .key_pressed    (key_pressed),
    .clear_turn_off (clear_turn_off),
    .regs           (regs),
    .evt            (evt),
    .turn_off_code  (turn_off_request),
    .press_trigger  (press_seen),
    .phase          (scan_phase),
    .press_ticks    (held_ticks)
  );

  pkc_timeout u_timeout (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .evt           (evt),
    .regs          (regs),
    .force_on_code (force_on_pending),
    .forced_on     (forced_on_active)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= accept | item_stall;
    end
  end

endmodule

// File: rtl/core/pkc_checker.sv
// port-level checker for the power key press classifier and its bind
module pkc_checker import pkc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input logic              press_seen,
  input logic [1:0]        scan_phase,
  input logic [CountW-1:0] held_ticks
);

  // every taken tick produces a result in the next cycle
  a_tick_gives_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> result_valid)
    else $error("accepted tick produced no result");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(held_ticks))
    else $error("stalled result changed");

  a_press_sticky: assert property (@(posedge clk) disable iff (rst)
    press_seen |=> press_seen)
    else $error("press flag dropped");

  // a press always counts at least one tick
  a_press_counts: assert property (@(posedge clk) disable iff (rst)
    scan_phase == PH_PRESS |-> held_ticks != '0)
    else $error("pressed phase with zero count");

  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    scan_phase != 2'd3)
    else $error("unused phase code reached");

endmodule

bind power_key_press_classifier pkc_checker u_pkc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .press_seen   (press_seen),
  .scan_phase   (scan_phase),
  .held_ticks   (held_ticks)
);
